// ===== rtl/bda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants of the binary to decimal ASCII unit
// Digit type, BCD correction constants, ASCII offset and the digit count
// needed for a given binary width.
// ----------------------------------------------------------------------------
package bda_pkg;

   typedef logic [3:0] bcd_digit_type;

   localparam logic [5:0]    ASCII_ZERO   = 6'd48;
   localparam bcd_digit_type BCD_ADJ_MIN  = 4'd5;
   localparam bcd_digit_type BCD_ADJ_STEP = 4'd3;
   localparam int            DIGIT_BITS   = 4;

   // decimal digits of 2**w - 1; 1233/4096 approximates log10(2)
   function automatic int num_digits(input int w);
      return ((w * 1233) >> 12) + 1;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/bda_dabble.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bda_dabble: bit-serial binary to BCD converter
// Shift-and-add-3 conversion, one binary bit per cycle.
// ----------------------------------------------------------------------------
module bda_dabble import bda_pkg::*; #(
   parameter int VALUE_WIDTH = 64,
   parameter int NUM_DIGITS  = 20
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire logic [VALUE_WIDTH-1:0]            value,
   output logic                                   busy,
   output logic                                   done,
   output logic [NUM_DIGITS*DIGIT_BITS-1:0]       bcd
);

   localparam int CNT_W  = $clog2(VALUE_WIDTH);
   localparam int BCD_W  = NUM_DIGITS * DIGIT_BITS;

   logic                   conv_ff, conv_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic                   last_shift;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      bcd_digit_type d;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         d = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
         if (d >= BCD_ADJ_MIN) begin
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = d + BCD_ADJ_STEP;
         end else begin
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = d;
         end
      end
   end

   assign last_shift = conv_ff && (cnt_ff == CNT_W'(VALUE_WIDTH - 1));

   always_comb begin
      conv_in = conv_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (load) begin
         conv_in = 1'b1;
         cnt_in  = '0;
         bin_in  = value;
         bcd_in  = '0;
      end else if (conv_ff) begin
         {bcd_in, bin_in} = {bcd_adj[BCD_W-2:0], bin_ff, 1'b0};
         cnt_in           = cnt_ff + CNT_W'(1);
         if (last_shift) begin
            conv_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         conv_ff <= conv_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign busy = conv_ff | done_ff;
   assign done = done_ff;
   assign bcd  = bcd_ff;

   a_done_ends_conv: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !conv_ff)
      else $error("conversion still running after done");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> (conv_ff && cnt_ff == '0))
      else $error("load did not start a conversion");

endmodule
`default_nettype wire

// ===== rtl/bda_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bda_emit: BCD digit serialiser
// Shifts out one BCD digit per cycle, most significant first, drops leading
// zeros and marks the final digit.
// ----------------------------------------------------------------------------
module bda_emit import bda_pkg::*; #(
   parameter int NUM_DIGITS = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic [NUM_DIGITS*DIGIT_BITS-1:0] bcd,
   output logic                               busy,
   output logic                               strobe,
   output logic [5:0]                         digit_char,
   output logic                               last
);

   localparam int IDX_W = $clog2(NUM_DIGITS);
   localparam int BCD_W = NUM_DIGITS * DIGIT_BITS;

   logic             active_ff, active_in;
   logic             lead_ff, lead_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [BCD_W-1:0] sreg_ff, sreg_in;
   logic             strobe_ff, strobe_in;
   logic [5:0]       char_ff, char_in;
   logic             last_ff, last_in;
   bcd_digit_type    digit;
   logic             final_digit;

   assign digit       = sreg_ff[BCD_W-1 -: DIGIT_BITS];
   assign final_digit = (idx_ff == '0);

   always_comb begin
      active_in = active_ff;
      lead_in   = lead_ff;
      idx_in    = idx_ff;
      sreg_in   = sreg_ff;
      strobe_in = 1'b0;
      char_in   = ASCII_ZERO + {2'b00, digit};
      last_in   = final_digit;
      if (load) begin
         active_in = 1'b1;
         lead_in   = 1'b0;
         idx_in    = IDX_W'(NUM_DIGITS - 1);
         sreg_in   = bcd;
      end else if (active_ff) begin
         // a digit goes out once a non-zero one is seen, and always the final one
         strobe_in = (digit != '0) || lead_ff || final_digit;
         lead_in   = lead_ff || (digit != '0);
         sreg_in   = {sreg_ff[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
         if (final_digit) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         lead_ff   <= 1'b0;
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         lead_ff   <= lead_in;
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sreg_ff <= sreg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy       = active_ff;
   assign strobe     = strobe_ff;
   assign digit_char = char_ff;
   assign last       = last_ff;

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      load |-> !active_ff)
      else $error("digits loaded while serialiser still active");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |=> !strobe_ff)
      else $error("digit emitted after final digit of a run");

endmodule
`default_nettype wire

// ===== rtl/binary_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit: unsigned binary to decimal ASCII text
// Converts one unsigned value into its decimal digit characters.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The value is
// converted by a shift-and-add-3 engine at one bit per cycle, then the BCD
// digits are shifted out one per cycle, all NUM_DIGITS positions including
// suppressed leading zeros. Busy stays high through the conversion and the
// serialisation, so a new value is not taken until the previous one has
// been fully sent; the final character is on the outputs in the cycle in
// which busy falls. Each character appears on rsp_digit_char for exactly one
// cycle with rsp_strobe high, most significant digit first, rsp_last marking
// the final one; zero gives the single character '0'. The receiver cannot
// stall the unit.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit import bda_pkg::*; #(
   parameter int VALUE_WIDTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   output logic                        rsp_strobe,
   output logic [5:0]                  rsp_digit_char,
   output logic                        rsp_last
);

   localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);

   logic                               load;
   logic                               dabble_busy;
   logic                               dabble_done;
   logic                               emit_busy;
   logic [NUM_DIGITS*DIGIT_BITS-1:0]   bcd;

   assign busy = dabble_busy | emit_busy;
   assign load = start & ~busy;

   bda_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .value (req_value),
      .busy  (dabble_busy),
      .done  (dabble_done),
      .bcd   (bcd)
   );

   bda_emit #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (dabble_done),
      .bcd        (bcd),
      .busy       (emit_busy),
      .strobe     (rsp_strobe),
      .digit_char (rsp_digit_char),
      .last       (rsp_last)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      load |=> busy)
      else $error("busy not raised after accepted transaction");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the binary to decimal ASCII unit
// Feeds directed and random 64-bit values through the start/busy handshake,
// predicts the decimal character stream of each accepted value and checks
// every strobed character and its last flag in order.
// ----------------------------------------------------------------------------
module tb_top;
   import bda_pkg::*;

   localparam int          VALUE_WIDTH  = 64;
   localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_WIDTH);
   localparam int          MAX_DIGITS   = 20;
   localparam int          RANDOM_ITEMS = 208;
   localparam int          DRAIN_EVERY  = 50;
   localparam int          SETTLE_CYCLES = 120;
   localparam int          CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [5:0] code;
      logic       last_flag;
   } digit_rec_type;

   typedef struct packed {
      logic [63:0] value;
      logic        drain_first;
   } pending_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [63:0] req_value = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [5:0]  rsp_digit_char;
   logic        rsp_last;

   pending_item_type pending_q[$];
   digit_rec_type    digit_q[$];

   int unsigned gap_left = 0;
   int unsigned calm_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned report_count = 0;
   int unsigned cycle_count = 0;
   pending_item_type next_item;
   digit_rec_type    want;

   binary_to_decimal_ascii_unit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] power_of_ten(input int unsigned exponent);
      logic [63:0] acc;
      acc = 64'd1;
      for (int i = 0; i < exponent; i++) acc = acc * 64'd10;
      return acc;
   endfunction

   // mostly short gaps, now and then a long one, and calm stretches with none
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      else if (roll < 90) return $urandom_range(1, 6);
      else return $urandom_range(20, 150);
   endfunction

   function automatic logic [63:0] random_value();
      int unsigned roll;
      int unsigned bits;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         bits = $urandom_range(1, 64);
         return random_word() >> (64 - bits);
      end else if (roll < 65) begin
         // straddle a digit-count boundary
         return power_of_ten($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
      end else if (roll < 80) begin
         return random_word();
      end else if (roll < 95) begin
         return 64'($urandom_range(0, 999));
      end else begin
         return ($urandom_range(0, 1) != 0) ? {64{1'b1}} : 64'd0;
      end
   endfunction

   // decimal characters of one transaction, most significant first
   task automatic predict_digits(input logic [63:0] raw);
      logic [63:0]   num;
      logic [3:0]    digs[MAX_DIGITS];
      int            count;
      digit_rec_type rec;
      num = raw & VALUE_MASK;
      count = 0;
      do begin
         digs[count] = 4'(num % 64'd10);
         num = num / 64'd10;
         count++;
      end while (num != 0 && count < MAX_DIGITS);
      for (int k = count - 1; k >= 0; k--) begin
         rec.code = ASCII_ZERO + {2'b00, digs[k]};
         rec.last_flag = (k == 0);
         digit_q.push_back(rec);
      end
   endtask

   task automatic queue_value(input logic [63:0] value, input logic drain_first);
      pending_item_type item;
      item.value = value;
      item.drain_first = drain_first;
      pending_q.push_back(item);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_value <= '0;
         gap_left = 0;
      end else begin
         if (start && !busy) predict_digits(req_value);
         if (start && busy) begin
            // hold the transaction until the unit takes it
         end else if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
            req_value <= random_word();
         end else if (pending_q.size() != 0
                      && !(pending_q[0].drain_first && digit_q.size() != 0)) begin
            next_item = pending_q.pop_front();
            start <= 1'b1;
            req_value <= next_item.value;
            if (calm_left != 0) begin
               calm_left--;
               gap_left = 0;
            end else begin
               gap_left = pick_gap();
               if ($urandom_range(0, 39) == 0) calm_left = 20;
            end
         end else begin
            start <= 1'b0;
            req_value <= random_word();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (digit_q.size() == 0) begin
            mismatch_count++;
            if (report_count < 10) begin
               report_count++;
               $display("unexpected character: code=%0d last=%0b",
                        rsp_digit_char, rsp_last);
            end
         end else begin
            want = digit_q.pop_front();
            if (rsp_digit_char !== want.code || rsp_last !== want.last_flag) begin
               mismatch_count++;
               if (report_count < 10) begin
                  report_count++;
                  $display("character mismatch: expected code=%0d last=%0b, got code=%0d last=%0b",
                           want.code, want.last_flag, rsp_digit_char, rsp_last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      // directed: zero, digit-count boundaries, word boundaries, full range
      queue_value(64'd0, 1'b0);
      queue_value(64'd1, 1'b0);
      queue_value(64'd9, 1'b0);
      queue_value(64'd10, 1'b0);
      queue_value(64'd11, 1'b0);
      queue_value(64'd99, 1'b0);
      queue_value(64'd100, 1'b0);
      queue_value(64'd101, 1'b0);
      queue_value(64'd1234567890, 1'b0);
      queue_value(64'd4294967295, 1'b0);
      queue_value(64'd4294967296, 1'b0);
      queue_value(64'd999999999999999999, 1'b0);
      queue_value(64'd1000000000000000000, 1'b0);
      queue_value(64'd9223372036854775807, 1'b0);
      queue_value(64'd9223372036854775808, 1'b0);
      queue_value(64'd9999999999999999999, 1'b0);
      queue_value(64'd10000000000000000000, 1'b0);
      queue_value(64'd12345678901234567890, 1'b0);
      queue_value(64'd18446744073709551615, 1'b0);
      queue_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      queue_value(64'h5555_5555_5555_5555, 1'b0);
      queue_value(64'd0, 1'b0);
      for (int i = 0; i < RANDOM_ITEMS; i++)
         queue_value(random_value(), (i % DRAIN_EVERY) == 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_q.size() != 0 || start || digit_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && digit_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== binary_to_decimal_ascii_unit.f =====
rtl/bda_pkg.sv
rtl/bda_dabble.sv
rtl/bda_emit.sv
rtl/binary_to_decimal_ascii_unit.sv
test/tb_top.sv
